/* sv/llp_pkg.sv */
// Shared types and constants for the layered lithostatic pressure block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package llp_pkg;

  // Input item kinds as carried in tuser.
  localparam logic [1:0] MODE_HEIGHT = 2'd0;
  localparam logic [1:0] MODE_DENS   = 2'd1;
  localparam logic [1:0] MODE_COMP   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LAYERS  = 3'd0;
  localparam logic [2:0] CFG_GRAVITY = 3'd1;
  localparam logic [2:0] CFG_DEPTH   = 3'd2;
  localparam logic [2:0] CFG_ROWS    = 3'd3;
  localparam logic [2:0] CFG_THREE   = 3'd4;

  localparam logic signed [63:0] P_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] P_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    K_HEIGHT,
    K_DENS,
    K_COMP
  } kind_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    kind_t        kind;
    logic [5:0]   x;
    logic [5:0]   y;
    logic [3:0]   li;
    logic [11:0]  row;
    logic [31:0]  value;
    logic         bad;
  } entry_t;

  typedef struct packed {
    logic [3:0]   layer_count;
    logic [15:0]  gravity_accel;
    logic [29:0]  domain_depth;
    logic [11:0]  rows_minus_one;
    logic         three_dim;
  } cfg_t;

  typedef struct packed {
    logic [63:0]  pressure;
    logic         saturated;
    logic         bad_index;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MULD,
    B_DINIT,
    B_DIV,
    B_ZSET,
    B_STEP,
    B_RD,
    B_ACC,
    B_CMP,
    B_MUL0,
    B_MUL1,
    B_MUL2,
    B_COMB,
    B_ADD,
    B_OUT
  } bstate_t;

endpackage

/* sv/llp_ram.sv */
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.
module llp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/llp_front.sv */
// Front end: accepts input items, drops unusable writes, flags bad computes.
// Depends on llp_pkg.
module llp_front #(
  parameter int MAX_LAYERS = 8,
  parameter int COLUMNS_X  = 64,
  parameter int COLUMNS_Y  = 64
) (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [63:0]     s_axis_tdata,
  input  logic [1:0]      s_axis_tuser,
  input  llp_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output llp_pkg::entry_t push_entry
);
  import llp_pkg::*;

  logic keep;

  assign s_axis_tready = !q_full;

  // Unpack the fields and classify the item.
  always_comb begin
    push_entry.x     = s_axis_tdata[5:0];
    push_entry.y     = s_axis_tdata[11:6];
    push_entry.li    = s_axis_tdata[15:12];
    push_entry.row   = s_axis_tdata[27:16];
    push_entry.value = s_axis_tdata[59:28];
    push_entry.kind  = K_COMP;
    push_entry.bad   = 1'b0;
    keep = 1'b0;
    case (s_axis_tuser)
      MODE_HEIGHT: begin
        push_entry.kind = K_HEIGHT;
        keep = (int'(push_entry.x) < COLUMNS_X) && (int'(push_entry.y) < COLUMNS_Y)
            && (int'(push_entry.li) < MAX_LAYERS);
      end
      MODE_DENS: begin
        push_entry.kind = K_DENS;
        keep = int'(push_entry.li) <= MAX_LAYERS;
      end
      MODE_COMP: begin
        keep = 1'b1;
        push_entry.bad = (int'(push_entry.x) + 1 >= COLUMNS_X)
            || (push_entry.row >= cfg.rows_minus_one)
            || (cfg.three_dim ? (int'(push_entry.y) + 1 >= COLUMNS_Y)
                              : (int'(push_entry.y) >= COLUMNS_Y));
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = s_axis_tvalid && !q_full && keep;

endmodule

/* sv/llp_queue.sv */
// Four-entry queue of classified items between the front and back ends.
// Depends on llp_pkg.
module llp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  llp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output llp_pkg::entry_t head
);
  import llp_pkg::*;

  entry_t     slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full       = count == 3'd4;
  assign head_valid = count != 3'd0;
  assign head       = slots[rptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

/* sv/llp_back.sv */
// Back end: runs writes and pressure computations from the queue in order.
// Depends on llp_pkg and llp_ram.
module llp_back #(
  parameter int MAX_LAYERS = 8,
  parameter int COLUMNS_X  = 64,
  parameter int COLUMNS_Y  = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  llp_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  llp_pkg::entry_t head,
  output logic            pop,
  input  logic            out_free,
  output logic            out_load,
  output llp_pkg::res_t   out_res
);
  import llp_pkg::*;

  localparam int PLANE = COLUMNS_X * COLUMNS_Y;
  localparam int DEPTH = MAX_LAYERS * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_LAYERS + 1);

  bstate_t state;
  bstate_t state_next;

  entry_t              cur;
  logic [15:0]         dens [MAX_LAYERS + 1];
  logic [41:0]         nprod;
  logic [45:0]         dq;
  logic [13:0]         rem;
  logic [5:0]          dcnt;
  logic signed [47:0]  z;
  logic signed [47:0]  upper;
  logic signed [47:0]  thick;
  logic signed [33:0]  hsum;
  logic [1:0]          corner;
  logic [DW-1:0]       j;
  logic                done;
  logic [31:0]         rho_g;
  logic [47:0]         mag;
  logic                neg;
  logic [55:0]         plo;
  logic [55:0]         phi;
  logic signed [63:0]  term;
  logic signed [63:0]  acc;
  logic                sat;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [31:0]         ram_rdata;
  logic [13:0]         trial;
  logic [12:0]         dvsr;
  logic signed [47:0]  lower;
  logic [79:0]         full_p;
  logic signed [64:0]  sum65;
  logic [1:0]          last_corner;
  int                  lc;

  llp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_heights (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head.value),
    .rdata (ram_rdata)
  );

  assign dvsr        = {cfg.rows_minus_one, 1'b0};
  assign trial       = {rem[12:0], dq[45]};
  assign last_corner = cfg.three_dim ? 2'd3 : 2'd1;
  assign lower       = cfg.three_dim ? 48'(hsum) : (48'(hsum) <<< 1);
  assign full_p      = {24'b0, plo} + {phi, 24'b0};
  assign sum65       = {acc[63], acc} + {term[63], term};
  assign lc          = int'(cfg.layer_count);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (head_valid && head.kind == K_COMP) begin
          state_next = head.bad ? B_OUT : B_MULD;
        end
      end
      B_MULD:  state_next = B_DINIT;
      B_DINIT: state_next = B_DIV;
      B_DIV:   state_next = (dcnt == 6'd45) ? B_ZSET : B_DIV;
      B_ZSET:  state_next = B_STEP;
      B_STEP:  state_next = (j == '0) ? B_MUL0 : B_RD;
      B_RD:    state_next = B_ACC;
      B_ACC:   state_next = (corner == last_corner) ? B_CMP : B_RD;
      B_CMP:   state_next = B_MUL0;
      B_MUL0:  state_next = B_MUL1;
      B_MUL1:  state_next = B_MUL2;
      B_MUL2:  state_next = B_COMB;
      B_COMB:  state_next = B_ADD;
      B_ADD:   state_next = done ? B_OUT : B_STEP;
      B_OUT:   state_next = out_free ? B_IDLE : B_OUT;
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs: queue pop, height memory port, result load.
  always_comb begin
    pop      = 1'b0;
    ram_we   = 1'b0;
    ram_addr = AW'(int'(head.li) * PLANE + int'(head.y) * COLUMNS_X + int'(head.x));
    out_load = 1'b0;
    case (state)
      B_IDLE: begin
        pop    = head_valid;
        ram_we = head_valid && head.kind == K_HEIGHT;
      end
      B_RD: begin
        ram_addr = AW'((int'(j) - 1) * PLANE
                     + (int'(cur.y) + int'(corner[1])) * COLUMNS_X
                     + int'(cur.x) + int'(corner[0]));
      end
      B_OUT: out_load = out_free;
      default: pop = 1'b0;
    endcase
  end

  assign out_res.pressure  = acc;
  assign out_res.saturated = sat;
  assign out_res.bad_index = cur.bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur  <= head;
        acc  <= '0;
        sat  <= 1'b0;
        if (head_valid && head.kind == K_DENS) begin
          for (int i = 0; i <= MAX_LAYERS; i++) begin
            if (int'(head.li) == i) begin
              dens[i] <= head.value[15:0];
            end
          end
        end
      end
      // Element depth numerator, then rounded division by rows.
      B_MULD: nprod <= cfg.domain_depth * (cfg.rows_minus_one - cur.row);
      B_DINIT: begin
        dq   <= {1'b0, nprod, 3'b0} + {34'b0, cfg.rows_minus_one};
        rem  <= '0;
        dcnt <= '0;
      end
      B_DIV: begin
        if (trial >= {1'b0, dvsr}) begin
          rem <= trial - {1'b0, dvsr};
          dq  <= {dq[44:0], 1'b1};
        end else begin
          rem <= trial;
          dq  <= {dq[44:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
      end
      B_ZSET: begin
        z     <= -$signed({2'b0, dq});
        upper <= '0;
        done  <= 1'b0;
        if (lc == 0) begin
          j <= DW'(1);
        end else if (lc > MAX_LAYERS) begin
          j <= DW'(MAX_LAYERS);
        end else begin
          j <= DW'(lc);
        end
      end
      // Bottom layer reaches down to the element.
      B_STEP: begin
        corner <= '0;
        hsum   <= '0;
        if (j == '0) begin
          done  <= 1'b1;
          thick <= upper - z;
        end
      end
      B_ACC: begin
        hsum   <= hsum + 34'($signed(ram_rdata));
        corner <= corner + 2'd1;
      end
      B_CMP: begin
        if (z > lower) begin
          done  <= 1'b1;
          thick <= upper - z;
        end else begin
          thick <= upper - lower;
          upper <= lower;
        end
      end
      B_MUL0: begin
        rho_g <= dens[j] * cfg.gravity_accel;
        neg   <= thick[47];
        mag   <= thick[47] ? 48'(-thick) : 48'(thick);
      end
      B_MUL1: plo <= rho_g * mag[23:0];
      B_MUL2: phi <= rho_g * mag[47:24];
      // Clamp the product to the signed 64-bit range.
      B_COMB: begin
        if (|full_p[79:63]) begin
          sat  <= 1'b1;
          term <= neg ? P_MIN : P_MAX;
        end else begin
          term <= neg ? -$signed(full_p[63:0]) : $signed(full_p[63:0]);
        end
      end
      B_ADD: begin
        if (sum65[64] != sum65[63]) begin
          sat <= 1'b1;
          acc <= sum65[64] ? P_MIN : P_MAX;
        end else begin
          acc <= sum65[63:0];
        end
        if (j != '0) begin
          j <= j - DW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/layered_lithostatic_pressure.sv */
// Top level of the layered lithostatic pressure block: configuration
// registers, output register, and the front/queue/back chain (llp_pkg).
//
//  channel   direction  handshake                payload
//  s_axis    in         s_axis_tvalid/tready     tdata: fields, tuser: mode
//  m_axis    out        m_axis_tvalid/tready     tdata: pressure, tuser: flags
//  cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// Writes are taken in the back end's idle state. A compute item is issued, finds
// the element depth (a multiply, then a 46-step division, one quotient bit per
// cycle), reads four heights per interface in 3D or two in 2D through the single
// height memory port, multiplies in parts, adds the bottom layer and loads the
// result; a bad element skips to the result. Reset is synchronous and clears
// control only; the height store is undefined until written. The four-entry
// queue and output register let input and output stall apart.
module layered_lithostatic_pressure #(
  parameter int MAX_LAYERS = 8,
  parameter int COLUMNS_X  = 64,
  parameter int COLUMNS_Y  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: column_x[5:0], column_y[11:6], layer_index[15:12],
  // row_index[27:16], write_value[59:28], zero fill
  input  logic [63:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pressure[63:0]
  output logic [63:0] m_axis_tdata,
  // tuser: saturated[0], bad_index[1]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import llp_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  res_t   out_res;
  logic   push;
  logic   q_full;
  logic   head_valid;
  logic   pop;
  logic   out_load;
  logic   res_valid;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_count    <= 4'd1;
      cfg.gravity_accel  <= 16'd10240;
      cfg.domain_depth   <= 30'd660000;
      cfg.rows_minus_one <= 12'd1;
      cfg.three_dim      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LAYERS:  cfg.layer_count    <= cfg_data[3:0];
        CFG_GRAVITY: cfg.gravity_accel  <= cfg_data[15:0];
        CFG_DEPTH:   cfg.domain_depth   <= cfg_data[29:0];
        CFG_ROWS:    cfg.rows_minus_one <= cfg_data[11:0];
        CFG_THREE:   cfg.three_dim      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  llp_front #(
    .MAX_LAYERS (MAX_LAYERS),
    .COLUMNS_X  (COLUMNS_X),
    .COLUMNS_Y  (COLUMNS_Y)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg           (cfg),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  llp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  llp_back #(
    .MAX_LAYERS (MAX_LAYERS),
    .COLUMNS_X  (COLUMNS_X),
    .COLUMNS_Y  (COLUMNS_Y)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_free   (!res_valid || m_axis_tready),
    .out_load   (out_load),
    .out_res    (out_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_res.pressure;
      m_axis_tuser <= {out_res.bad_index, out_res.saturated};
    end
  end

  assign m_axis_tvalid = res_valid;

endmodule

/* test/tb.sv */
// Testbench for layered_lithostatic_pressure: directed table, then random phases.
// Depends on llp_pkg and the RTL only; checks each result against predictor or table.
`timescale 1ns / 1ps

module tb;
  import llp_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  layered_lithostatic_pressure dut (.*);

  localparam int PLANE = 64 * 64;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic [63:0] pressure;
    bit          saturated;
    bit          bad_index;
  } pressure_t;

  typedef struct {
    logic [1:0]  mode;
    int          x;
    int          y;
    int          li;
    int          row;
    logic [31:0] value;
    bit          typed;
    pressure_t   res;
  } row_t;

  // Predictor state: configuration and both stores.
  int unsigned      heights[int];
  logic [15:0]      densities[9];
  int unsigned      n_layers;
  int unsigned      gravity;
  int unsigned      depth_m;
  int unsigned      rows_m1;
  bit               three_d;

  pressure_t        pending[$];
  int               errors;
  bit               quiet;
  bit               hold_req;
  int               hold_len;
  int               pos[5] = '{0, 1, 2, 62, 63};
  int               xgood[3] = '{0, 1, 62};

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("[layered_lithostatic_pressure] ERROR");
    $finish;
  end

  function automatic longint height_of(int k, int x, int y);
    return longint'(signed'(heights[k * PLANE + y * 64 + x]));
  endfunction

  // Density times gravity times thickness, clamped to 64 bits.
  function automatic longint layer_term(int k, longint thick, inout bit sat);
    logic [127:0]        a, m, prod;
    logic signed [127:0] t;
    bit                  neg;
    t = thick;
    neg = thick < 0;
    m = neg ? -t : t;
    a = 128'(densities[k]) * 128'(gravity);
    prod = a * m;
    if (prod > 128'(P_MAX)) begin
      sat = 1;
      return neg ? P_MIN : P_MAX;
    end
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clamp_add(longint acc, longint b, inout bit sat);
    logic signed [64:0] sum;
    sum = 65'(acc) + 65'(b);
    if (sum > 65'(P_MAX)) begin
      sat = 1;
      return P_MAX;
    end
    if (sum < 65'(P_MIN)) begin
      sat = 1;
      return P_MIN;
    end
    return longint'(sum[63:0]);
  endfunction

  function automatic pressure_t element_pressure(int x, int y, int row);
    pressure_t   r;
    longint      h[8];
    longint      z, p;
    logic [63:0] num, den;
    int          n;
    bit          sat, done;
    r = '{0, 0, 0};
    if (x + 1 >= 64 || row >= int'(rows_m1) || (three_d ? y + 1 >= 64 : y >= 64)) begin
      r.bad_index = 1;
      return r;
    end
    n = (n_layers == 0) ? 1 : (n_layers > 8) ? 8 : n_layers;
    for (int k = 0; k < n; k++) begin
      if (three_d)
        h[k] = height_of(k, x, y) + height_of(k, x + 1, y)
             + height_of(k, x, y + 1) + height_of(k, x + 1, y + 1);
      else
        h[k] = 2 * (height_of(k, x, y) + height_of(k, x + 1, y));
    end
    num = 64'd4 * depth_m * (rows_m1 - row);
    den = rows_m1;
    z = -longint'((2 * num + den) / (2 * den));
    sat = 0;
    p = 0;
    if (z > h[n-1]) begin
      p = clamp_add(p, layer_term(n, -z, sat), sat);
    end else begin
      done = 0;
      p = clamp_add(p, layer_term(n, -h[n-1], sat), sat);
      for (int k = n - 1; k > 0 && !done; k--) begin
        if (z > h[k-1]) begin
          p = clamp_add(p, layer_term(k, h[k] - z, sat), sat);
          done = 1;
        end else begin
          p = clamp_add(p, layer_term(k, h[k] - h[k-1], sat), sat);
        end
      end
      if (!done) p = clamp_add(p, layer_term(0, h[0] - z, sat), sat);
    end
    r.pressure = p;
    r.saturated = sat;
    return r;
  endfunction

  // Offer one item, wait for acceptance, then update the predictor.
  task automatic send_item(logic [1:0] mode, int x, int y, int li, int row,
                           logic [31:0] value, bit typed = 0,
                           pressure_t res = '{0, 0, 0});
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, value, 12'(row), 4'(li), 6'(y), 6'(x)};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (mode)
      MODE_HEIGHT: if (li < 8) heights[li * PLANE + y * 64 + x] = value;
      MODE_DENS:   if (li <= 8) densities[li] = value[15:0];
      MODE_COMP:   pending.push_back(typed ? res : element_pressure(x, y, row));
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_LAYERS:  n_layers = value[3:0];
      CFG_GRAVITY: gravity  = value[15:0];
      CFG_DEPTH:   depth_m  = value[29:0];
      CFG_ROWS:    rows_m1  = value[11:0];
      CFG_THREE:   three_d  = value[0];
      default: ;
    endcase
  endtask

  // Let every result drain and the back end finish trailing writes.
  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] random_height();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return -$urandom_range(0, 700000);
    if (pick < 75) return $urandom_range(0, 100);
    return $urandom;
  endfunction

  task automatic random_item();
    int pick, x, y, row;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // Compute items: mostly inside the written columns, some bad elements.
      x = xgood[$urandom_range(0, 2)];
      y = three_d ? xgood[$urandom_range(0, 2)] : pos[$urandom_range(0, 4)];
      row = (rows_m1 == 0) ? $urandom_range(0, 4095) : $urandom_range(0, rows_m1 - 1);
      case ($urandom_range(0, 9))
        0: begin
          x = 63;
          y = $urandom_range(0, 63);
        end
        1: if (three_d) y = 63;
        2: row = $urandom_range(rows_m1, 4095);
        default: ;
      endcase
      send_item(MODE_COMP, x, y, 0, row, 0);
    end else if (pick < 75) begin
      if (pick < 66)
        send_item(MODE_HEIGHT, pos[$urandom_range(0, 4)], pos[$urandom_range(0, 4)],
                  $urandom_range(0, 7), $urandom_range(0, 4095), random_height());
      else if (pick < 72)
        send_item(MODE_HEIGHT, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 7), $urandom_range(0, 4095), $urandom);
      else
        send_item(MODE_HEIGHT, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(8, 15), 0, $urandom);
    end else if (pick < 92) begin
      send_item(MODE_DENS, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 8), $urandom_range(0, 4095),
                (pick < 85) ? $urandom_range(1000, 4000) : $urandom);
    end else if (pick < 96) begin
      send_item(MODE_DENS, 0, 0, $urandom_range(9, 15), 0, $urandom);
    end else begin
      send_item(MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 15), $urandom_range(0, 4095), $urandom);
    end
  endtask

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    pressure_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result: pressure %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata !== want.pressure) begin
          $error("pressure: expected %h, got %h", want.pressure, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.saturated) begin
          $error("saturated: expected %0d, got %b", want.saturated, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.bad_index) begin
          $error("bad_index: expected %0d, got %b", want.bad_index, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 0;
        repeat (hold_len) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_axis_tready <= 1;
    end
  end

  // Directed stimulus under the reset configuration (one interface, 2D, one row).
  row_t directed[] = '{
    '{MODE_DENS,   0,  0,  0, 0, 32'd2700,     0, '{0, 0, 0}},
    '{MODE_DENS,   0,  0,  1, 0, 32'd3300,     0, '{0, 0, 0}},
    '{MODE_DENS,   0,  0,  8, 0, 32'h0000ffff, 0, '{0, 0, 0}},
    '{MODE_DENS,   0,  0,  9, 0, 32'd123,      0, '{0, 0, 0}},
    '{MODE_DENS,   0,  0, 15, 0, 32'hffffffff, 0, '{0, 0, 0}},
    '{MODE_HEIGHT, 0,  0,  0, 0, -32'sd1000,   0, '{0, 0, 0}},
    '{MODE_HEIGHT, 1,  0,  0, 0, -32'sd3000,   0, '{0, 0, 0}},
    '{MODE_HEIGHT, 2,  0,  0, 0, -32'sd500,    0, '{0, 0, 0}},
    '{MODE_HEIGHT, 62, 0,  0, 0, 32'h7fffffff, 0, '{0, 0, 0}},
    '{MODE_HEIGHT, 63, 0,  0, 0, 32'h7fffffff, 0, '{0, 0, 0}},
    '{MODE_HEIGHT, 63, 63, 7, 4095, 32'h80000000, 0, '{0, 0, 0}},
    '{MODE_HEIGHT, 0,  0,  8, 0, 32'h12345678, 0, '{0, 0, 0}},
    '{MODE_NONE,   63, 63, 15, 4095, 32'hffffffff, 0, '{0, 0, 0}},
    '{MODE_COMP,   0,  0,  0, 0, 0,            0, '{0, 0, 0}},
    '{MODE_COMP,   62, 0,  0, 0, 0,            0, '{0, 0, 0}},
    '{MODE_COMP,   63, 0,  0, 0, 0,            1, '{0, 0, 1}},
    '{MODE_COMP,   0,  0,  0, 1, 0,            1, '{0, 0, 1}},
    '{MODE_COMP,   63, 63, 0, 4095, 0,         1, '{0, 0, 1}},
    '{MODE_COMP,   1,  0,  0, 0, 0,            0, '{0, 0, 0}}
  };

  initial begin
    clk = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    quiet = 0;
    hold_req = 0;
    hold_len = 0;
    n_layers = 1;
    gravity = 10240;
    depth_m = 660000;
    rows_m1 = 1;
    three_d = 0;
    foreach (densities[i]) densities[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].mode, directed[i].x, directed[i].y, directed[i].li,
                directed[i].row, directed[i].value, directed[i].typed, directed[i].res);

    // Fill every density and every interface at the columns that computes use.
    for (int k = 0; k <= 8; k++)
      send_item(MODE_DENS, 0, 0, k, 0, $urandom_range(1000, 4000));
    for (int k = 0; k < 8; k++)
      foreach (pos[i])
        foreach (pos[j])
          send_item(MODE_HEIGHT, pos[i], pos[j], k, 0, random_height());

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_LAYERS, 8);
          write_reg(CFG_GRAVITY, 65535);
          write_reg(CFG_DEPTH, 32'h3fffffff);
          write_reg(CFG_ROWS, 4095);
          write_reg(CFG_THREE, 1);
        end
        1: begin
          write_reg(CFG_LAYERS, 0);
          write_reg(CFG_GRAVITY, 0);
          write_reg(CFG_DEPTH, 1);
          write_reg(CFG_ROWS, 1);
          write_reg(CFG_THREE, 0);
        end
        2: begin
          write_reg(CFG_LAYERS, 15);
          write_reg(CFG_ROWS, 0);
          write_reg(CFG_THREE, 1);
        end
        default: begin
          write_reg(CFG_LAYERS, $urandom_range(1, 8));
          write_reg(CFG_GRAVITY, $urandom_range(9000, 11000));
          write_reg(CFG_DEPTH, $urandom_range(1000, 700000));
          write_reg(CFG_ROWS, $urandom_range(1, 200));
          write_reg(CFG_THREE, $urandom_range(0, 1));
        end
      endcase
      if (ph == 4) begin
        hold_len = 3000;
        hold_req = 1;
      end
      quiet = (ph == 7);
      repeat (130) random_item();
    end

    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("[layered_lithostatic_pressure] OK");
    else
      $display("[layered_lithostatic_pressure] ERROR");
    $finish;
  end

endmodule
